>>> rtl/log_table_interpolated_interval_unit_macros.svh
// assertion macros shared by the checker of the interval factor unit
// no dependencies; expects clk and rst_n in the scope of use
`ifndef LOG_TABLE_INTERPOLATED_INTERVAL_UNIT_MACROS_SVH
`define LOG_TABLE_INTERPOLATED_INTERVAL_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define LTI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define LTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lti_pkg.sv
// shared types, widths and codes for the interpolated interval factor unit
// no dependencies
package lti_pkg;

    localparam int TABLE_LENGTH_DEF  = 1000;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int NUM_TABLES        = 3;

    localparam int ENTRY_W  = 48;
    localparam int HALF_W   = 24;
    localparam int TIME_W   = 31;
    localparam int SEL_W    = 2;
    localparam int IDX_W    = 10;
    localparam int FACTOR_W = 49;
    localparam int VAL_W    = 49;

    localparam int IDX_LSB = 0;
    localparam int VAL_LSB = IDX_LSB + IDX_W;
    localparam int T0_LSB  = VAL_LSB + ENTRY_W;
    localparam int T1_LSB  = T0_LSB + TIME_W;

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic                   ACT_LOAD  = 1'b0;
    localparam logic                   ACT_QUERY = 1'b1;
    localparam logic [SEL_W-1:0]       SEL_NONE  = 2'd3;
    localparam logic [APB_ADDR_W-3:0]  REG_TIME_BASE = '0;
    localparam logic [TIME_W-1:0]      TIME_BASE_RESET = 31'h4000_0000;

endpackage

>>> rtl/lti_ram.sv
// generic single-write single-read memory with registered read data
// depends on lti_pkg for default widths
module lti_ram
    import lti_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = NUM_TABLES * TABLE_LENGTH_DEF
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/log_table_interpolated_interval_unit.sv
// interval factor unit: a query runs a multiply step and the two bit-per-cycle position
// dividers side by side, then per time the low and high reads through one memory port,
// difference, high and low partial products and sum (four reads, four products in all);
// during a query, input waits until its result is registered, once the output is free
// loads write on acceptance; reset clears control and sets time_base to 2^30, tables undefined
// depends on lti_pkg and lti_ram
module log_table_interpolated_interval_unit
    import lti_pkg::*;
#(
    parameter int TABLE_LENGTH  = TABLE_LENGTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index, entry_value, time_start, time_end
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // action, table_select
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // factor
    output logic [M_TDATA_W-1:0]  m_tdata,
    // table_used
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LB    = $clog2(TABLE_LENGTH + 1);
    localparam int QW    = LB + FRACTION_BITS;
    localparam int PW    = TIME_W + LB;
    localparam int DEPTH = NUM_TABLES * TABLE_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = FRACTION_BITS + 2;
    localparam int PHW   = HALF_W + BW;
    localparam int CW    = $clog2(QW + 1);
    localparam int SUM_W = VAL_W + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_RD_LO = 4'd3;
    localparam logic [3:0] S_RD_HI = 4'd4;
    localparam logic [3:0] S_DIFF  = 4'd5;
    localparam logic [3:0] S_MHI   = 4'd6;
    localparam logic [3:0] S_MLO   = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [TIME_W-1:0]   time_base_reg, time_base_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                lane_reg, lane_next;
    logic                m_valid_reg, m_valid_next;

    logic [SEL_W-1:0]    sel_reg, sel_next;
    logic [TIME_W-1:0]   t_reg [2];
    logic [TIME_W-1:0]   t_next [2];
    logic [TIME_W-1:0]   rem_reg [2];
    logic [TIME_W-1:0]   rem_next [2];
    logic [QW-1:0]       sh_reg [2];
    logic [QW-1:0]       sh_next [2];
    logic [ENTRY_W-1:0]  lo_reg, lo_next;
    logic [ENTRY_W-1:0]  a_reg, a_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [ENTRY_W-1:0]  base_reg, base_next;
    logic                neg_reg, neg_next;
    logic [PHW-1:0]      phi_reg, phi_next;
    logic [PHW-1:0]      plo_reg, plo_next;
    logic [VAL_W-1:0]    v_reg [2];
    logic [VAL_W-1:0]    v_next [2];
    logic [FACTOR_W-1:0] m_data_reg, m_data_next;
    logic [SEL_W-1:0]    m_user_reg, m_user_next;

    logic                in_action;
    logic [SEL_W-1:0]    in_sel;
    logic [IDX_W-1:0]    in_idx;
    logic [ENTRY_W-1:0]  in_val;
    logic [TIME_W-1:0]   in_t0;
    logic [TIME_W-1:0]   in_t1;
    logic                s_accept;
    logic                out_free;
    logic [TIME_W-1:0]   tb_eff;

    logic [PW-1:0]       prod [2];
    logic [TIME_W:0]     trial [2];
    logic                ge [2];

    logic [QW-1:0]       u_cur;
    logic [LB-1:0]       bin_raw;
    logic [LB-1:0]       bin_cl;
    logic                small_bin;
    logic [QW-1:0]       frac_full;
    logic [AW-1:0]       base_addr;
    logic [SUM_W-1:0]    scaled;
    logic [SUM_W-1:0]    value;
    logic [SUM_W-1:0]    diff;
    logic [FACTOR_W-1:0] diff_sat;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                cfg_wr;
    logic                cfg_hit;

    function automatic logic [AW-1:0] table_base(input logic [SEL_W-1:0] sel);
        return AW'(int'(sel) * TABLE_LENGTH);
    endfunction

    assign in_action = s_tuser[0];
    assign in_sel    = s_tuser[SEL_W:1];
    assign in_idx    = s_tdata[IDX_LSB +: IDX_W];
    assign in_val    = s_tdata[VAL_LSB +: ENTRY_W];
    assign in_t0     = s_tdata[T0_LSB +: TIME_W];
    assign in_t1     = s_tdata[T1_LSB +: TIME_W];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign tb_eff   = (time_base_reg == '0) ? TIME_W'(1) : time_base_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - FACTOR_W){1'b0}}, m_data_reg};
    assign m_tuser  = m_user_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_TIME_BASE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_hit ? APB_DATA_W'(time_base_reg) : '0;

    // table memory
    assign wr_en   = s_accept && (in_action == ACT_LOAD) && (in_sel != SEL_NONE)
                     && (32'(in_idx) < 32'(TABLE_LENGTH));
    assign wr_addr = table_base(in_sel) + AW'(in_idx);

    lti_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // position dividers, one quotient bit per cycle and lane
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            prod[k]  = PW'(t_reg[k]) * PW'(TABLE_LENGTH);
            trial[k] = {rem_reg[k], sh_reg[k][QW-1]};
            ge[k]    = (trial[k] >= {1'b0, tb_eff});
        end
    end

    // bin and fraction of the current lane
    always_comb
    begin
        u_cur   = sh_reg[lane_reg];
        bin_raw = u_cur[QW-1:FRACTION_BITS];
        if (bin_raw > LB'(TABLE_LENGTH - 1))
        begin
            bin_cl = LB'(TABLE_LENGTH - 1);
        end
        else if (bin_raw == '0)
        begin
            bin_cl = LB'(1);
        end
        else
        begin
            bin_cl = bin_raw;
        end
        small_bin = (bin_cl == LB'(1));
        frac_full = u_cur - {bin_cl, {FRACTION_BITS{1'b0}}};
        base_addr = table_base(sel_reg);
    end

    always_comb
    begin
        rd_en   = (state_reg == S_RD_LO) || (state_reg == S_RD_HI);
        rd_addr = base_addr + AW'(bin_cl);
        if (state_reg == S_RD_LO)
        begin
            rd_addr = small_bin ? base_addr : base_addr + AW'(bin_cl) - AW'(1);
        end
    end

    always_comb
    begin
        scaled = (SUM_W'(phi_reg) << (HALF_W - FRACTION_BITS))
                 + SUM_W'(plo_reg >> FRACTION_BITS);
        value  = neg_reg ? SUM_W'(base_reg) - scaled : SUM_W'(base_reg) + scaled;
        diff   = {1'b0, v_reg[1]} - {1'b0, v_reg[0]};
        if (diff[SUM_W-1] == diff[SUM_W-2])
        begin
            diff_sat = diff[FACTOR_W-1:0];
        end
        else if (diff[SUM_W-1] == 1'b0)
        begin
            diff_sat = {1'b0, {(FACTOR_W-1){1'b1}}};
        end
        else
        begin
            diff_sat = {1'b1, {(FACTOR_W-1){1'b0}}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        time_base_next = time_base_reg;
        cnt_next       = cnt_reg;
        lane_next      = lane_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        sel_next       = sel_reg;
        t_next         = t_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        lo_next        = lo_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        base_next      = base_reg;
        neg_next       = neg_reg;
        phi_next       = phi_reg;
        plo_next       = plo_reg;
        v_next         = v_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        if (cfg_wr && cfg_hit)
        begin
            time_base_next = pwdata[TIME_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (in_action == ACT_QUERY) && (in_sel != SEL_NONE))
                begin
                    sel_next   = in_sel;
                    t_next[0]  = (in_t0 > tb_eff) ? tb_eff : in_t0;
                    t_next[1]  = (in_t1 > tb_eff) ? tb_eff : in_t1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    rem_next[k] = prod[k][PW-1:LB];
                    sh_next[k]  = {prod[k][LB-1:0], {FRACTION_BITS{1'b0}}};
                end
                cnt_next   = CW'(QW);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    rem_next[k] = ge[k] ? TIME_W'(trial[k] - {1'b0, tb_eff})
                                        : trial[k][TIME_W-1:0];
                    sh_next[k]  = {sh_reg[k][QW-2:0], ge[k]};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    lane_next  = 1'b0;
                    state_next = S_RD_LO;
                end
            end
            S_RD_LO:
            begin
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                lo_next    = rd_data;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                if (small_bin)
                begin
                    a_next    = lo_reg;
                    b_next    = u_cur[BW-1:0];
                    base_next = '0;
                    neg_next  = 1'b0;
                end
                else
                begin
                    neg_next  = (rd_data < lo_reg);
                    a_next    = (rd_data < lo_reg) ? lo_reg - rd_data : rd_data - lo_reg;
                    b_next    = frac_full[BW-1:0];
                    base_next = lo_reg;
                end
                state_next = S_MHI;
            end
            S_MHI:
            begin
                phi_next   = PHW'(a_reg[ENTRY_W-1:HALF_W]) * PHW'(b_reg);
                state_next = S_MLO;
            end
            S_MLO:
            begin
                plo_next   = PHW'(a_reg[HALF_W-1:0]) * PHW'(b_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                v_next[lane_reg] = value[VAL_W-1:0];
                if (lane_reg == 1'b0)
                begin
                    lane_next  = 1'b1;
                    state_next = S_RD_LO;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = diff_sat;
                    m_user_next  = sel_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_base_reg <= TIME_BASE_RESET;
            cnt_reg       <= '0;
            lane_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_base_reg <= time_base_next;
            cnt_reg       <= cnt_next;
            lane_reg      <= lane_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        t_reg      <= t_next;
        rem_reg    <= rem_next;
        sh_reg     <= sh_next;
        lo_reg     <= lo_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        base_reg   <= base_next;
        neg_reg    <= neg_next;
        phi_reg    <= phi_next;
        plo_reg    <= plo_next;
        v_reg      <= v_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

>>> rtl/lti_checker.sv
// port-level checks of the interval factor unit, bound to the top level
// depends on lti_pkg and log_table_interpolated_interval_unit_macros.svh
`include "log_table_interpolated_interval_unit_macros.svh"

module lti_checker
    import lti_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TUSER_W-1:0]  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [M_TUSER_W-1:0]  m_tuser
);

    logic in_take;
    logic take_query;
    logic take_load;
    logic out_stall;

    assign in_take    = s_tvalid && s_tready;
    assign take_query = in_take && (s_tuser[0] == ACT_QUERY)
                        && (s_tuser[SEL_W:1] != SEL_NONE);
    assign take_load  = in_take && (s_tuser[0] == ACT_LOAD);
    assign out_stall  = m_tvalid && !m_tready;

    // stalled result transaction holds
    `LTI_ASSERT_NEXT(a_hold, out_stall, m_tvalid && $stable({m_tdata, m_tuser}), "result changed")

    // a valid query keeps the unit busy
    `LTI_ASSERT_NEXT(a_query_busy, take_query, !s_tready, "query did not occupy the unit")

    // a load leaves the input ready in the next cycle
    `LTI_ASSERT_NEXT(a_load_quick, take_load, s_tready, "load stalled the input")

    // answering table is a real one
    `LTI_ASSERT_SAME(a_table_known, m_tvalid, m_tuser != SEL_NONE, "result from unknown table")

    // a new result leaves the unit ready for the next transaction
    `LTI_ASSERT_SAME(a_result_ready, $rose(m_tvalid), s_tready, "unit busy at new result")

endmodule

bind log_table_interpolated_interval_unit lti_checker u_lti_checker (.*);

>>> verif/tb_log_table_interpolated_interval_unit.sv
// testbench for log_table_interpolated_interval_unit: directed rows, then random phases
// checked against an in-bench interpolation predictor; depends on lti_pkg and the rtl
module tb_log_table_interpolated_interval_unit;
    import lti_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int TLEN = TABLE_LENGTH_DEF;
    localparam int FRAC = FRACTION_BITS_DEF;
    localparam int SETTLE = 48;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int CYCLE_LIMIT = 800000;
    localparam logic [TIME_W-1:0] T_TOP = '1;
    localparam logic [ENTRY_W-1:0] ENTRY_TOP = '1;
    localparam longint FACTOR_MAX = 64'sh0000_FFFF_FFFF_FFFF;
    localparam longint FACTOR_MIN = -64'sh0001_0000_0000_0000;
    localparam logic [FACTOR_W-1:0] FACTOR_TOP = 49'h0_FFFF_FFFF_FFFF;
    localparam logic [FACTOR_W-1:0] FACTOR_BOTTOM = 49'h1_0000_0000_0000;
    localparam logic [FACTOR_W-1:0] FACTOR_NEG_TOP = 49'h1_0000_0000_0001;

    typedef struct packed {
        logic act;
        logic [SEL_W-1:0] sel;
        logic [IDX_W-1:0] idx;
        logic [ENTRY_W-1:0] val;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;
    } work_item_t;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [SEL_W-1:0] table_id;
    } answer_t;

    typedef enum logic {ROW_ITEM, ROW_BASE} row_kind_e;

    typedef struct packed {
        row_kind_e kind;
        work_item_t item;
        logic [TIME_W-1:0] base;
        logic fixed_answer;
        logic [FACTOR_W-1:0] factor;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid;
    logic s_tready;
    // entry_index, entry_value, time_start, time_end
    logic [S_TDATA_W-1:0] s_tdata;
    // action, table_select
    logic [S_TUSER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // factor
    logic [M_TDATA_W-1:0] m_tdata;
    // table_used
    logic [M_TUSER_W-1:0] m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    logic [ENTRY_W-1:0] entry_store [NUM_TABLES][TLEN];
    bit entry_written [NUM_TABLES][TLEN];
    logic [TIME_W-1:0] base_model = TIME_BASE_RESET;
    answer_t pending_answers [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    logic [1:0] stall_mode = 2'd0;

    log_table_interpolated_interval_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // floor(a * b / 2^FRAC), split to stay inside 64 bits
    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] upper;
        logic [63:0] lower;
        upper = a >> 24;
        lower = a & 64'hFF_FFFF;
        return ((upper * b) << (24 - FRAC)) + ((lower * b) >> FRAC);
    endfunction

    function automatic logic [63:0] position_of_time(input logic [TIME_W-1:0] t_in);
        logic [63:0] tb;
        logic [63:0] t;
        logic [63:0] prod;
        logic [63:0] whole;
        logic [63:0] rest;
        tb = (base_model == '0) ? 64'd1 : 64'(base_model);
        t = 64'(t_in);
        if (t > tb)
            t = tb;
        prod = t * 64'(TLEN);
        whole = prod / tb;
        rest = prod % tb;
        return (whole << FRAC) + ((rest << FRAC) / tb);
    endfunction

    function automatic logic [63:0] clamped_bin(input logic [63:0] u);
        logic [63:0] bin;
        bin = u >> FRAC;
        if (bin > 64'(TLEN - 1))
            bin = 64'(TLEN - 1);
        if (bin < 64'd1)
            bin = 64'd1;
        return bin;
    endfunction

    function automatic longint interpolated_value(input logic [SEL_W-1:0] sel,
                                                  input logic [63:0] u);
        logic [63:0] bin;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] frac;
        bin = clamped_bin(u);
        if (bin <= 64'd1)
            return longint'(scaled_product(64'(entry_store[sel][0]), u));
        lo = 64'(entry_store[sel][bin - 1]);
        hi = 64'(entry_store[sel][bin]);
        frac = u - (bin << FRAC);
        if (hi >= lo)
            return longint'(lo + scaled_product(hi - lo, frac));
        return longint'(lo) - longint'(scaled_product(lo - hi, frac));
    endfunction

    function automatic logic [FACTOR_W-1:0] interval_factor(input logic [SEL_W-1:0] sel,
                                                            input logic [TIME_W-1:0] t0,
                                                            input logic [TIME_W-1:0] t1);
        longint diff;
        diff = interpolated_value(sel, position_of_time(t1))
             - interpolated_value(sel, position_of_time(t0));
        if (diff > FACTOR_MAX)
            diff = FACTOR_MAX;
        if (diff < FACTOR_MIN)
            diff = FACTOR_MIN;
        return diff[FACTOR_W-1:0];
    endfunction

    function automatic work_item_t random_item();
        work_item_t w;
        w.act = 1'($urandom_range(1));
        w.sel = SEL_W'($urandom_range(NUM_TABLES - 1));
        w.idx = IDX_W'($urandom_range(TLEN - 1));
        w.val = {16'($urandom), $urandom};
        w.t0 = TIME_W'($urandom);
        w.t1 = TIME_W'($urandom);
        return w;
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(9))
            0: return '0;
            1: return base_model;
            2: return T_TOP;
            3, 4: return TIME_W'($urandom);
            default: return TIME_W'($urandom_range(base_model));
        endcase
    endfunction

    function automatic plan_row_t load_row(input logic [SEL_W-1:0] sel,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [ENTRY_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item.act = ACT_LOAD;
        r.item.sel = sel;
        r.item.idx = idx;
        r.item.val = val;
        return r;
    endfunction

    function automatic plan_row_t query_row(input logic [SEL_W-1:0] sel,
                                            input logic [TIME_W-1:0] t0,
                                            input logic [TIME_W-1:0] t1,
                                            input logic fixed_answer,
                                            input logic [FACTOR_W-1:0] factor);
        plan_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item.act = ACT_QUERY;
        r.item.sel = sel;
        r.item.t0 = t0;
        r.item.t1 = t1;
        r.fixed_answer = fixed_answer;
        r.factor = factor;
        return r;
    endfunction

    function automatic plan_row_t base_row(input logic [TIME_W-1:0] base);
        plan_row_t r;
        r = '0;
        r.kind = ROW_BASE;
        r.base = base;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic record_transaction(input work_item_t w, input logic fixed_answer,
                                      input logic [FACTOR_W-1:0] fixed_factor);
        answer_t a;
        if (w.sel == SEL_NONE)
            return;
        if (w.act == ACT_LOAD) begin
            if (w.idx < IDX_W'(TLEN))
            begin
                entry_store[w.sel][w.idx] = w.val;
                entry_written[w.sel][w.idx] = 1'b1;
            end
            return;
        end
        a.factor = fixed_answer ? fixed_factor : interval_factor(w.sel, w.t0, w.t1);
        a.table_id = w.sel;
        pending_answers.push_back(a);
    endtask

    task automatic send_item(input work_item_t w, input logic fixed_answer,
                             input logic [FACTOR_W-1:0] fixed_factor);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(5))
                0, 1: gap = 0;
                2: gap = $urandom_range(20, 50);
                default: gap = $urandom_range(1, 10);
            endcase
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {w.t1, w.t0, w.val, w.idx};
        s_tuser <= {w.sel, w.act};
        do
            @(posedge clk);
        while (!s_tready);
        record_transaction(w, fixed_answer, fixed_factor);
        items_sent++;
    endtask

    task automatic drain(input int unsigned settle);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_time_base(input logic [TIME_W-1:0] base);
        drain(SETTLE);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TIME_BASE, 2'b00};
        pwdata <= APB_DATA_W'(base);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        base_model = base;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // loads whatever entries a query at this time would read but are still unwritten
    task automatic fill_entries_for(input logic [SEL_W-1:0] sel, input logic [TIME_W-1:0] t_in);
        logic [63:0] bin;
        int idx;
        work_item_t ld;
        bin = clamped_bin(position_of_time(t_in));
        for (int k = 0; k < 2; k++) begin
            idx = (bin <= 64'd1) ? 0 : int'(bin) - 1 + k;
            if (!entry_written[sel][idx])
            begin
                ld = random_item();
                ld.act = ACT_LOAD;
                ld.sel = sel;
                ld.idx = IDX_W'(idx);
                send_item(ld, 1'b0, '0);
            end
        end
    endtask

    always @(negedge clk) begin
        if (stall_left == 0)
        begin
            stall_mode <= 2'($urandom_range(3));
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= 1'($urandom_range(1));
            2'd2: m_tready <= (stall_left[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(15) == 0);
        endcase
    end

    always @(posedge clk) begin
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("result with nothing pending", 64'(m_tdata), '0);
            else
            begin
                want = pending_answers.pop_front();
                if (m_tdata[FACTOR_W-1:0] !== want.factor)
                    report_mismatch("factor", 64'(m_tdata[FACTOR_W-1:0]), 64'(want.factor));
                if (m_tuser !== want.table_id)
                    report_mismatch("table_used", 64'(m_tuser), 64'(want.table_id));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_log_table_interpolated_interval_unit NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        plan_row_t directed_plan [23];
        logic [TIME_W-1:0] random_bases [8];
        work_item_t item;
        int unsigned roll;
        int unsigned phase_goal;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (entry_store[s, i]) begin
            entry_store[s][i] = '0;
            entry_written[s][i] = 1'b0;
        end
        directed_plan = '{
            query_row(SEL_NONE, '0, T_TOP, 1'b0, '0),
            load_row(2'd0, 10'd0, ENTRY_TOP),
            load_row(2'd0, 10'd998, '0),
            load_row(2'd0, 10'd999, ENTRY_TOP),
            load_row(SEL_NONE, 10'd5, 48'h1234_5678_9ABC),
            load_row(2'd0, 10'd1023, 48'h5555_AAAA_5555),
            load_row(2'd0, 10'd1000, ENTRY_TOP),
            query_row(2'd0, '0, '0, 1'b1, '0),
            query_row(2'd0, '0, TIME_BASE_RESET, 1'b1, FACTOR_TOP),
            query_row(2'd0, '0, T_TOP, 1'b1, FACTOR_TOP),
            query_row(2'd0, T_TOP, '0, 1'b1, FACTOR_NEG_TOP),
            query_row(2'd0, 31'd500000, 31'd1600000, 1'b0, '0),
            base_row(31'd2000),
            query_row(2'd0, '0, 31'd3, 1'b1, FACTOR_TOP),
            query_row(2'd0, 31'd3, '0, 1'b1, FACTOR_BOTTOM),
            load_row(2'd1, 10'd0, 48'h0001_0000_0000),
            query_row(2'd1, 31'd1, 31'd2, 1'b0, '0),
            query_row(SEL_NONE, 31'd1, 31'd2, 1'b0, '0),
            base_row('0),
            query_row(2'd0, '0, 31'd1, 1'b1, FACTOR_TOP),
            base_row(T_TOP),
            load_row(2'd2, 10'd0, 48'h8000_0000_0001),
            query_row(2'd2, 31'd5000, 31'd3000000, 1'b0, '0)
        };
        random_bases = '{
            31'd1, TIME_BASE_RESET, T_TOP, 31'd1000, 31'd7,
            TIME_W'($urandom_range(2, 1 << 20)), '0, TIME_W'($urandom)
        };
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[r]) begin
            if (directed_plan[r].kind == ROW_BASE)
                set_time_base(directed_plan[r].base);
            else
                send_item(directed_plan[r].item, directed_plan[r].fixed_answer,
                          directed_plan[r].factor);
        end

        foreach (random_bases[p]) begin
            set_time_base(random_bases[p]);
            phase_goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_goal) begin
                item = random_item();
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    if ($urandom_range(1) == 0)
                        item.sel = SEL_NONE;
                    else
                    begin
                        item.act = ACT_LOAD;
                        item.idx = IDX_W'($urandom_range(TLEN, (1 << IDX_W) - 1));
                    end
                end
                else if (roll < 38)
                begin
                    item.act = ACT_LOAD;
                    case ($urandom_range(7))
                        0: item.val = '0;
                        1: item.val = ENTRY_TOP;
                        default: ;
                    endcase
                end
                else
                begin
                    item.act = ACT_QUERY;
                    item.t0 = pick_time();
                    item.t1 = pick_time();
                    fill_entries_for(item.sel, item.t0);
                    fill_entries_for(item.sel, item.t1);
                end
                send_item(item, 1'b0, '0);
                // hold off now and then until the block has caught up
                if ($urandom_range(199) == 0)
                    drain(0);
            end
        end

        drain(SETTLE);
        if (error_count == 0)
            $display("tb_log_table_interpolated_interval_unit OK");
        else
            $display("tb_log_table_interpolated_interval_unit NOT OK");
        $finish;
    end

endmodule

>>> log_table_interpolated_interval_unit.f
+incdir+rtl
rtl/lti_pkg.sv
rtl/lti_ram.sv
rtl/log_table_interpolated_interval_unit.sv
rtl/lti_checker.sv
verif/tb_log_table_interpolated_interval_unit.sv
